// File: rtl/rqk_pkg.sv
`timescale 1ns / 1ps

package rqk_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [63:0] ROMU_MULT = 64'd15241094284759029579;
  localparam logic [31:0] MULT_LO   = ROMU_MULT[31:0];
  localparam logic [31:0] MULT_HI   = ROMU_MULT[63:32];
  localparam int unsigned ROT_W     = 52;
  localparam int unsigned ROT_Z     = 19;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_KEY,
    OP_DATA
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic       last;
    logic [2:0] kpos;
  } item_t;

  // sign-extended key byte placed at byte lane (kpos + off) mod 8
  function automatic logic [63:0] lane_mask(input logic [7:0] kb, input logic [2:0] kpos,
                                            input logic [2:0] off);
    logic [63:0] kv;
    logic [2:0]  lane;
    kv   = {{56{kb[7]}}, kb};
    lane = kpos + off;
    return kv << {lane, 3'b000};
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

endpackage

// File: rtl/rqk_if.sv
`timescale 1ns / 1ps

interface rqk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

interface rqk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// File: rtl/rqk_front.sv
`timescale 1ns / 1ps

module rqk_front
  import rqk_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  rqk_in_if.sink din,
  input  logic   full,
  output logic   push,
  output item_t  push_item
);

  logic [2:0] key_pos;
  logic       accept;

  assign din.ready = !full;
  assign accept    = din.valid && !full;

  always_comb begin
    push_item.value = din.value;
    push_item.last  = din.last;
    push_item.kpos  = key_pos;
    push_item.op    = OP_CLEAR;
    push            = 1'b0;
    case (din.kind)
      KIND_CLEAR: begin
        push_item.op = OP_CLEAR;
        push         = accept;
      end
      KIND_KEY: begin
        push_item.op = OP_KEY;
        push         = accept;
      end
      KIND_DATA: begin
        push_item.op = OP_DATA;
        push         = accept;
      end
      default: begin
        // unused kind is taken and dropped
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pos <= '0;
    end else if (accept) begin
      if (din.kind == KIND_CLEAR) begin
        key_pos <= '0;
      end else if (din.kind == KIND_KEY) begin
        key_pos <= key_pos + 3'd1;
      end
    end
  end

endmodule

// File: rtl/rqk_fifo.sv
`timescale 1ns / 1ps

module rqk_fifo
  import rqk_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/rqk_back.sv
`timescale 1ns / 1ps

module rqk_back
  import rqk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  item_t      head,
  output logic       pop,
  rqk_out_if.source  dout
);

  // w is held as partial products of the multiply, XORed with a key mask
  logic [63:0] p0;
  logic [31:0] p1;
  logic [31:0] p2;
  logic [63:0] w_mask;
  logic [63:0] gen_x;
  logic [63:0] gen_y;
  logic [63:0] gen_z;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  logic        out_free;
  logic [63:0] w_cur;
  logic [31:0] w_hi;
  logic [63:0] p0_next;
  logic [31:0] p1_next;
  logic [31:0] p2_next;
  logic [63:0] x_next;
  logic [63:0] z_next;
  logic [63:0] yw_sum;

  assign out_free = !out_valid || dout.ready;
  assign pop      = head_valid && ((head.op != OP_DATA) || out_free);

  assign dout.valid    = out_valid;
  assign dout.out_byte = out_byte;
  assign dout.out_last = out_last;

  always_comb begin
    w_hi    = p0[63:32] + p1 + p2;
    w_cur   = {w_hi, p0[31:0]} ^ w_mask;
    x_next  = gen_z + rotl64(w_cur, ROT_W);
    yw_sum  = gen_y + w_cur;
    z_next  = rotl64(yw_sum, ROT_Z);
    p0_next = gen_z[31:0] * MULT_LO;
    p1_next = gen_z[63:32] * MULT_LO;
    p2_next = gen_z[31:0] * MULT_HI;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0     <= '0;
      p1     <= '0;
      p2     <= '0;
      w_mask <= '0;
      gen_x  <= '0;
      gen_y  <= '0;
      gen_z  <= '0;
    end else if (pop) begin
      case (head.op)
        OP_CLEAR: begin
          p0     <= '0;
          p1     <= '0;
          p2     <= '0;
          w_mask <= '0;
          gen_x  <= '0;
          gen_y  <= '0;
          gen_z  <= '0;
        end
        OP_KEY: begin
          w_mask <= w_mask ^ lane_mask(head.value, head.kpos, 3'd0);
          gen_x  <= gen_x ^ lane_mask(head.value, head.kpos, 3'd1);
          gen_y  <= gen_y ^ lane_mask(head.value, head.kpos, 3'd2);
          gen_z  <= gen_z ^ lane_mask(head.value, head.kpos, 3'd3);
        end
        OP_DATA: begin
          p0     <= p0_next;
          p1     <= p1_next;
          p2     <= p2_next;
          w_mask <= '0;
          gen_x  <= x_next;
          gen_y  <= gen_y - gen_x;
          gen_z  <= z_next;
        end
        default: begin
          w_mask <= w_mask;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && (head.op == OP_DATA)) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == OP_DATA)) begin
      out_byte <= head.value ^ gen_x[7:0];
      out_last <= head.last;
    end
  end

endmodule

// File: rtl/romu_quad_keystream_cipher.sv
`timescale 1ns / 1ps
// path: a data byte is stored in the queue; its result is registered at the output when popped
// throughput: one item per cycle unless dout.ready is low, set by the generator step in the back end
//   (multiply split into partial products of 32-bit halves, summed in the next step)
// reset: synchronous rst zeroes the generator words, key position, queue and output valid flag

module romu_quad_keystream_cipher
  import rqk_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  rqk_in_if.sink    din,
  rqk_out_if.source dout
);

  logic  full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  head_valid;
  item_t head;

  rqk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  rqk_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rqk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .dout       (dout)
  );

endmodule
